// File: src/fir128_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the coefficient table for the 128-tap FIR filter.
// No dependencies; every other file of the filter uses this package.
package fir128_pkg;

    localparam int TAPS                = 128;
    localparam int ACC_BITS            = 40;
    localparam int COEF_BITS           = 20;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef logic signed [ACC_BITS-1:0]  acc_t;

    // Controls handed from the input stage to every tap cell
    typedef struct packed {
        logic advance;
        logic primed;
    } tap_ctrl_t;

    localparam coef_t COEFS [TAPS] = '{
        -20'sd2,    20'sd10,   20'sd14,   20'sd7,    -20'sd7,   -20'sd17,  -20'sd13,  20'sd3,
        20'sd19,    20'sd21,   20'sd4,    -20'sd21,  -20'sd32,  -20'sd16,  20'sd18,   20'sd43,
        20'sd34,    -20'sd8,   -20'sd51,  -20'sd56,  -20'sd11,  20'sd53,   20'sd81,   20'sd41,
        -20'sd44,   -20'sd104, -20'sd81,  20'sd19,   20'sd119,  20'sd129,  20'sd24,   -20'sd119,
        -20'sd178,  -20'sd88,  20'sd95,   20'sd222,  20'sd171,  -20'sd41,  -20'sd248, -20'sd266,
        -20'sd50,   20'sd244,  20'sd366,  20'sd181,  -20'sd195, -20'sd457, -20'sd353, 20'sd85,
        20'sd522,   20'sd568,  20'sd109,  -20'sd540, -20'sd831, -20'sd424, 20'sd474,  20'sd1163,
        20'sd953,   -20'sd245, -20'sd1661, -20'sd2042, -20'sd463, 20'sd2940, 20'sd6859,
        20'sd9469,
        20'sd9469,  20'sd6859, 20'sd2940, -20'sd463, -20'sd2042, -20'sd1661, -20'sd245,
        20'sd953,
        20'sd1163,  20'sd474,  -20'sd424, -20'sd831, -20'sd540, 20'sd109,  20'sd568,  20'sd522,
        20'sd85,    -20'sd353, -20'sd457, -20'sd195, 20'sd181,  20'sd366,  20'sd244,  -20'sd50,
        -20'sd266,  -20'sd248, -20'sd41,  20'sd171,  20'sd222,  20'sd95,   -20'sd88,  -20'sd178,
        -20'sd119,  20'sd24,   20'sd129,  20'sd119,  20'sd19,   -20'sd81,  -20'sd104, -20'sd44,
        20'sd41,    20'sd81,   20'sd53,   -20'sd11,  -20'sd56,  -20'sd51,  -20'sd8,   20'sd34,
        20'sd43,    20'sd18,   -20'sd16,  -20'sd32,  -20'sd21,  20'sd4,    20'sd21,   20'sd19,
        20'sd3,     -20'sd13,  -20'sd17,  -20'sd7,   20'sd7,    20'sd14,   20'sd10,   -20'sd2
    };

    // Sum of the coefficients from tap 'first' to the end. Used when the first
    // sample stands for the whole history: evaluated at elaboration only.
    function automatic coef_t prime_coef(input int first);
        int acc;
        acc = 0;
        for (int j = first; j < TAPS; j++) begin
            acc = acc + int'(COEFS[j]);
        end
        return coef_t'(acc);
    endfunction

endpackage

// File: src/fir128_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the FIR filter's sample and result channels.
// Depends on fir128_pkg for default widths.
interface fir128_sample_if #(
    parameter int WIDTH = fir128_pkg::SAMPLE_BITS_DEFAULT
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface fir128_result_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [fir128_pkg::ACC_BITS-1:0]   filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

// File: src/fir128_tap.sv
`timescale 1ns / 1ps
// One cell of the transposed FIR chain: constant multiply, add, partial-sum register.
// Depends on fir128_pkg.
module fir128_tap #(
    parameter int SAMPLE_BITS = fir128_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                          clk,
    input  fir128_pkg::tap_ctrl_t         ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  fir128_pkg::coef_t             coef_run,
    input  fir128_pkg::coef_t             coef_prime,
    input  fir128_pkg::acc_t              chain_in,
    output fir128_pkg::acc_t              chain_out
);
    import fir128_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;

    coef_t                         coef_sel;
    logic signed [PROD_BITS-1:0]   prod;
    acc_t                          sum_reg;
    acc_t                          sum_next;

    // Before the first beat the history is all one sample: use the suffix sum
    // of the coefficients and drop whatever the chain holds.
    assign coef_sel = ctrl.primed ? coef_run : coef_prime;
    assign prod     = PROD_BITS'(sample) * PROD_BITS'(coef_sel);
    assign sum_next = ACC_BITS'(prod) + (ctrl.primed ? chain_in : acc_t'(0));

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            sum_reg <= sum_next;
        end
    end

    assign chain_out = sum_reg;

endmodule

// File: src/fir_filter_128_tap.sv
`timescale 1ns / 1ps
// Streaming 128-tap FIR filter, signed Q1.15 samples in, exact 40-bit sums out
// (scale 2^-15, no rounding, wraps modulo 2^40 only if samples are made wider).
// One sample is taken every clock while the output is free. A sample beat loads
// the input register, and its sum then loads the result register.
// A stalled result holds the input once the input register also holds a sample;
// with the output free, the input never stalls. The rate is set by the transposed
// tap chain: 127 partial-sum registers, each fed by one constant multiply and one
// add per beat, plus the output tap between the input register and the result
// register. The first sample after reset stands for all older samples it has no
// history for.
// Depends on fir128_pkg, fir128_stream_if and fir128_tap.
module fir_filter_128_tap #(
    parameter int SAMPLE_BITS = fir128_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    fir128_sample_if.sink     samples,
    fir128_result_if.source   results
);
    import fir128_pkg::*;

    localparam int    PROD_BITS  = SAMPLE_BITS + COEF_BITS;
    localparam coef_t HEAD_PRIME = prime_coef(0);

    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          primed_reg;
    logic                          out_valid_reg;
    acc_t                          filtered_reg;

    logic                          s1_fire;
    logic                          in_fire;
    tap_ctrl_t                     ctrl;
    acc_t                          chain [1:TAPS];
    coef_t                         head_coef;
    logic signed [PROD_BITS-1:0]   head_prod;
    acc_t                          filtered_next;

    // Advance the chain only when the held beat moves into the result register
    assign s1_fire       = s1_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !s1_valid_reg || s1_fire;
    assign in_fire       = samples.valid && samples.ready;

    assign ctrl.advance  = s1_fire;
    assign ctrl.primed   = primed_reg;

    assign chain[TAPS]   = '0;

    for (genvar k = 1; k < TAPS; k++)
    begin : g_tap
        localparam coef_t PRIME_C = prime_coef(k);

        fir128_tap #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_tap (
            .clk        (clk),
            .ctrl       (ctrl),
            .sample     (sample_reg),
            .coef_run   (COEFS[k]),
            .coef_prime (PRIME_C),
            .chain_in   (chain[k+1]),
            .chain_out  (chain[k])
        );
    end

    // Output tap: newest sample x COEFS[0] + chain head; unprimed, x full coef sum
    assign head_coef     = primed_reg ? COEFS[0] : HEAD_PRIME;
    assign head_prod     = PROD_BITS'(sample_reg) * PROD_BITS'(head_coef);
    assign filtered_next = ACC_BITS'(head_prod) + (primed_reg ? chain[1] : acc_t'(0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                primed_reg    <= 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg <= SAMPLE_BITS'(samples.sample);
        end
        if (s1_fire)
        begin
            filtered_reg <= filtered_next;
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.filtered = filtered_reg;

endmodule

// File: src/fir128_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the FIR filter, bound to its top level.
// Depends on fir128_pkg and fir_filter_128_tap.
module fir128_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input fir128_pkg::acc_t filtered
);
    import fir128_pkg::*;

    // A stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(filtered))
        else $error("result payload changed while stalled");

    // With the output free, the filter never refuses a sample
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("sample refused while output not stalled");

    // A new result appears only after a sample beat has passed the input register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching sample beat");

endmodule

bind fir_filter_128_tap fir128_checker u_fir128_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .filtered  (results.filtered)
);
